// File: rtl/core/bpa_pkg.sv
// Package of shared constants, codes and types for the bitmap page allocator.
package bpa_pkg;

  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned PSIZE_W   = 21;
  localparam int unsigned PCOUNT_W  = 9;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned MAX_PAGES = 256;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned NUM_WORDS = MAX_PAGES / WORD_W;
  localparam int unsigned BIT_W     = $clog2(WORD_W);
  localparam int unsigned ROW_W     = $clog2(NUM_WORDS);
  localparam int unsigned PIDX_W    = $clog2(MAX_PAGES);
  localparam int unsigned LIMIT_W   = $clog2(MAX_PAGES + 1);
  localparam int unsigned PROD_W    = PIDX_W + PSIZE_W;
  localparam int unsigned DIV_STEPS = ADDR_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [PSIZE_W-1:0]  PAGE_SIZE_RST  = PSIZE_W'(4096);
  localparam logic [PCOUNT_W-1:0] PAGE_COUNT_RST = PCOUNT_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_BASE = 2'd0,
    CFG_PAGE_SIZE   = 2'd1,
    CFG_PAGE_COUNT  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_FULL      = 2'd1,
    ST_FREED     = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

endpackage

// File: rtl/core/bpa_if.sv
// Channel interfaces of the bitmap page allocator: request, response, configuration.
interface bpa_req_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output kind, output address, input ready);
  modport sink   (input valid, input kind, input address, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] page_address;
  logic [1:0]        status;

  modport source (output valid, output page_address, output status, input ready);
  modport sink   (input valid, input page_address, input status, output ready);
endinterface

interface bpa_cfg_if import bpa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ADDR_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/bitmap_page_allocator.sv
// Bitmap first-fit page allocator: top level with bitmap memory, divider and sequencer.
// Allocate: rows are read and scanned in turn from row 0; a found page is marked, then
//   its address is computed; a full store ends the scan; 8 rows of 32 pages.
// Free: bit-serial divide of offset by page size, then clear the page bit if in range.
// One transaction in flight; the next request is accepted while a response waits.
// Reset (rst_ni low, async) marks every page free through per-row valid bits, at once;
//   registers return to base 0, page size 4096, page count 256.
module bitmap_page_allocator import bpa_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  bpa_cfg_if.sink   cfg_i,
  bpa_req_if.sink   req_i,
  bpa_rsp_if.source rsp_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_READ = 6'b000100,
    S_SCAN = 6'b001000,
    S_CALC = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  // Configuration registers
  logic [ADDR_W-1:0]   region_base_q;
  logic [PSIZE_W-1:0]  page_size_q;
  logic [PCOUNT_W-1:0] page_count_q;

  // Sequencer state
  state_e              state_q, state_d;
  logic                kind_q, kind_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [BIT_W-1:0]    bit_q, bit_d;
  logic [ADDR_W-1:0]   div_q, div_d;
  logic [PSIZE_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  status_e             status_q, status_d;

  // Response register
  logic                rsp_valid_q, rsp_valid_d;
  logic [ADDR_W-1:0]   rsp_addr_q, rsp_addr_d;
  status_e             rsp_status_q, rsp_status_d;

  // Bitmap memory: one row of WORD_W page bits per entry, registered read
  logic [WORD_W-1:0]    mem_q [NUM_WORDS];
  logic [WORD_W-1:0]    rd_data_q;
  logic                 rd_vld_q;
  logic [NUM_WORDS-1:0] row_vld_q, row_vld_d;
  logic                 mem_we;
  logic [WORD_W-1:0]    mem_wdata;

  // Combinational helpers
  logic [LIMIT_W-1:0]  limit;
  logic [WORD_W-1:0]   eff_word;
  logic [WORD_W-1:0]   avail;
  logic                found;
  logic [BIT_W-1:0]    fbit;
  logic [LIMIT_W-1:0]  next_base;
  logic [PSIZE_W:0]    trial;
  logic [PSIZE_W:0]    trial_sub;
  logic                qbit;
  logic [ADDR_W-1:0]   quot;
  logic                idx_ok;
  logic                rsp_load;
  logic                req_fire;

  // Pages above the store act as the full store.
  assign limit = (page_count_q > PCOUNT_W'(MAX_PAGES)) ? LIMIT_W'(MAX_PAGES)
                                                       : LIMIT_W'(page_count_q);

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.page_address = rsp_addr_q;
  assign rsp_o.status       = rsp_status_q;

  // A row never written since reset reads as all pages free.
  assign eff_word = rd_vld_q ? rd_data_q : '0;

  // Free pages in the current row that lie below the page count
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      avail[b] = !eff_word[b] && (LIMIT_W'({row_q, BIT_W'(b)}) < limit);
    end
  end

  // Lowest free page in the row
  always_comb begin
    found = 1'b0;
    fbit  = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (avail[b]) begin
        found = 1'b1;
        fbit  = BIT_W'(b);
      end
    end
  end

  // First page index of the following row; at or past the limit ends the scan.
  assign next_base = LIMIT_W'({(ROW_W + 1)'({1'b0, row_q}) + (ROW_W + 1)'(1),
                               {BIT_W{1'b0}}});

  // One restoring step of offset / page size. A zero page size yields all ones.
  assign trial     = {rem_q, div_q[ADDR_W-1]};
  assign trial_sub = trial - {1'b0, page_size_q};
  assign qbit      = (trial >= {1'b0, page_size_q});
  assign quot      = {div_q[ADDR_W-2:0], qbit};

  // Range check of the quotient once the divide is done
  assign idx_ok = ((quot >> LIMIT_W) == '0) && (quot[LIMIT_W-1:0] < limit);

  assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    row_d        = row_q;
    bit_d        = bit_q;
    div_d        = div_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    prod_d       = prod_q;
    status_d     = status_q;
    row_vld_d    = row_vld_q;
    mem_we       = 1'b0;
    mem_wdata    = eff_word;
    rsp_valid_d  = rsp_valid_q;
    rsp_addr_d   = rsp_addr_q;
    rsp_status_d = rsp_status_q;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          kind_d = req_i.kind;
          if (req_i.kind == KIND_FREE) begin
            // Offset wraps modulo the address width.
            div_d   = req_i.address - region_base_q;
            rem_d   = '0;
            cnt_d   = '0;
            state_d = S_DIV;
          end else begin
            row_d   = '0;
            state_d = S_READ;
          end
        end
      end

      S_DIV: begin
        div_d = quot;
        rem_d = qbit ? trial_sub[PSIZE_W-1:0] : trial[PSIZE_W-1:0];
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          if (idx_ok) begin
            row_d   = quot[PIDX_W-1:BIT_W];
            bit_d   = quot[BIT_W-1:0];
            state_d = S_READ;
          end else begin
            status_d = ST_RANGE;
            state_d  = S_DONE;
          end
        end
      end

      S_READ: begin
        // Row data lands in rd_data_q at this edge.
        state_d = S_SCAN;
      end

      S_SCAN: begin
        if (kind_q == KIND_FREE) begin
          mem_we           = 1'b1;
          mem_wdata        = eff_word & ~(WORD_W'(1) << bit_q);
          row_vld_d[row_q] = 1'b1;
          status_d         = ST_FREED;
          state_d          = S_DONE;
        end else if (found) begin
          mem_we           = 1'b1;
          mem_wdata        = eff_word | (WORD_W'(1) << fbit);
          row_vld_d[row_q] = 1'b1;
          bit_d            = fbit;
          status_d         = ST_ALLOCATED;
          state_d          = S_CALC;
        end else if (next_base >= limit) begin
          status_d = ST_FULL;
          state_d  = S_DONE;
        end else begin
          row_d   = row_q + ROW_W'(1);
          state_d = S_READ;
        end
      end

      S_CALC: begin
        prod_d  = PROD_W'({row_q, bit_q}) * PROD_W'(page_size_q);
        state_d = S_DONE;
      end

      S_DONE: begin
        // Hold here until the response register is free.
        if (rsp_load) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = status_q;
          rsp_addr_d   = (status_q == ST_ALLOCATED)
                         ? region_base_q + ADDR_W'(prod_q) : '0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      rsp_valid_q   <= 1'b0;
      row_vld_q     <= '0;
      rd_vld_q      <= 1'b0;
      region_base_q <= '0;
      page_size_q   <= PAGE_SIZE_RST;
      page_count_q  <= PAGE_COUNT_RST;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      row_vld_q   <= row_vld_d;
      rd_vld_q    <= row_vld_q[row_q];
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_REGION_BASE: region_base_q <= cfg_i.data;
          CFG_PAGE_SIZE:   page_size_q   <= cfg_i.data[PSIZE_W-1:0];
          CFG_PAGE_COUNT:  page_count_q  <= cfg_i.data[PCOUNT_W-1:0];
          default: begin
            // Drop writes to unmapped indexes.
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    row_q        <= row_d;
    bit_q        <= bit_d;
    div_q        <= div_d;
    rem_q        <= rem_d;
    cnt_q        <= cnt_d;
    prod_q       <= prod_d;
    status_q     <= status_d;
    rsp_addr_q   <= rsp_addr_d;
    rsp_status_q <= rsp_status_d;
  end

  // Bitmap memory: write on check, read the addressed row every cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[row_q] <= mem_wdata;
    end
    rd_data_q <= mem_q[row_q];
  end

endmodule
